/* sv/spd_pkg.sv */
package spd_pkg;

  // Sample and gain formats
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;
  localparam int FB_BITS     = 15;
  localparam int GAIN_SHIFT  = 15;
  localparam int DELAY_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + 3;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = 16'h8000;

  localparam int LINE_DEPTH_DEF = 65536;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WET      = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_t;

  // Per-item pipeline strobes shared by both lanes
  typedef struct packed {
    logic rd_en;    // request accepted, line read issued
    logic rd_zero;  // read entry never written since reset
    logic s2_load;  // read stage moves to product stage
    logic wr_en;    // product stage retires, line written
  } lane_ctl_t;

  // Clamp a widened sum to the signed sample range
  function automatic sample_t sat_sample(input logic signed [SUM_BITS-1:0] v);
    logic [SUM_BITS-SAMPLE_BITS:0] top;
    top = v[SUM_BITS-1:SAMPLE_BITS-1];
    if (top == '0 || top == '1) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

/* sv/stereo_ping_pong_delay.sv */
// Pipeline: an accepted request passes the read stage, the product stage and the output
// register. Throughput: one request per cycle while the output is not stalled and the
// effective delay (delay_samples modulo line depth) is not 1 or 2; then a request waits
// for the earlier write it reads. Requests are held off while a delay write settles.
// Reset (rst_n, synchronous): registers to their defaults, pipeline empty; line
// entries not yet written read as zero through a fill flag, no clearing pass.
module stereo_ping_pong_delay
  import spd_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_t                      in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_t                     out_data
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(LINE_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(LINE_DEPTH - 1);
  localparam logic [1:0]    SETTLE  = 2'd2;

  // configuration
  logic [DELAY_BITS-1:0] delay_r;
  logic [FB_BITS-1:0]    fb_r;
  logic [GAIN_BITS-1:0]  wet_r;
  logic [GAIN_BITS-1:0]  dry_r;
  logic [GAIN_BITS-1:0]  wet_clip;
  logic [1:0]            settle_r;
  logic [AW-1:0]         dmod_r;

  // pipeline control
  logic [AW-1:0] wp_r;
  logic          filled_r;
  logic          s1_v_r, s1_v_nxt;
  logic          s2_v_r, s2_v_nxt;
  logic          out_v_r, out_v_nxt;
  logic [AW-1:0] s1_wp_r;
  logic [AW-1:0] s2_wp_r;
  out_t          out_data_r;

  logic          out_free, s2_free, s1_free;
  logic          mv1, mv2, acc, hazard;
  logic [AW:0]   diff;
  logic [AW-1:0] rd_addr;
  lane_ctl_t     ctl;
  sample_t       l_mix, r_mix;

  // register writes; wet clipped to unity, dry derived once here
  assign wet_clip = (cfg_wdata > GAIN_ONE) ? GAIN_ONE : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_BITS'(1);
      fb_r     <= '0;
      wet_r    <= '0;
      dry_r    <= GAIN_ONE;
      settle_r <= '0;
    end else begin
      // a delay write restarts the settle count
      if (cfg_we && cfg_idx == REG_DELAY) begin
        settle_r <= SETTLE;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 2'd1;
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_DELAY:    delay_r <= cfg_wdata;
          REG_FEEDBACK: fb_r <= cfg_wdata[FB_BITS-1:0];
          REG_WET: begin
            wet_r <= wet_clip;
            dry_r <= GAIN_ONE - wet_clip;
          end
          default: ;
        endcase
      end
    end
  end

  // delay modulo line depth: two register steps for a shallow line, else taken directly
  generate
    if (LINE_DEPTH < (1 << DELAY_BITS)) begin : g_mod
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / LINE_DEPTH);
      localparam logic [DELAY_BITS:0] DEPTH_R = (DELAY_BITS+1)'(LINE_DEPTH);
      logic [DELAY_BITS-1:0] q_r;
      logic [DELAY_BITS+31:0] qp;
      logic [31:0]            qd;
      logic [DELAY_BITS:0]    rem;
      logic [DELAY_BITS:0]    rem_fix;

      // quotient estimate by reciprocal, low by at most one
      assign qp = delay_r * RECIP;
      assign qd = 32'(q_r) * 32'(LINE_DEPTH);
      assign rem = (DELAY_BITS+1)'(32'(delay_r) - qd);
      assign rem_fix = (rem >= DEPTH_R) ? rem - DEPTH_R : rem;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          q_r    <= '0;
          dmod_r <= AW'(1);
        end else begin
          q_r    <= qp[DELAY_BITS+31:32];
          dmod_r <= rem_fix[AW-1:0];
        end
      end
    end else begin : g_wide
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dmod_r <= AW'(1);
        end else begin
          dmod_r <= AW'(delay_r);
        end
      end
    end
  endgenerate

  // read address, wrapped into the line
  assign diff    = {1'b0, wp_r} - {1'b0, dmod_r};
  assign rd_addr = diff[AW] ? AW'(diff + DEPTH_W) : diff[AW-1:0];

  // hold a request whose entry is still to be written by an item in flight
  assign hazard = (s1_v_r && rd_addr == s1_wp_r) || (s2_v_r && rd_addr == s2_wp_r);

  // stage moves, each stage advances into a free or draining one
  assign out_free = !out_v_r || !out_stall;
  assign mv2      = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign mv1      = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_stall = !s1_free || hazard || (settle_r != '0);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (mv1) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (mv1) begin
      s2_v_nxt = 1'b1;
    end else if (mv2) begin
      s2_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (mv2) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      wp_r     <= '0;
      filled_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (acc) begin
        if (wp_r == WP_LAST) begin
          wp_r     <= '0;
          filled_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
    end
  end

  // write address travels with the item
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_wp_r <= wp_r;
    end
    if (mv1) begin
      s2_wp_r <= s1_wp_r;
    end
  end

  assign ctl.rd_en   = acc;
  assign ctl.rd_zero = !(filled_r || rd_addr < wp_r);
  assign ctl.s2_load = mv1;
  assign ctl.wr_en   = mv2;

  // left line takes the right input, right line the left input
  spd_lane #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_lane_l (
    .clk      (clk),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (s2_wp_r),
    .own_in   (in_data.left_in),
    .cross_in (in_data.right_in),
    .fb_gain  (fb_r),
    .wet_gain (wet_r),
    .dry_gain (dry_r),
    .mix_out  (l_mix)
  );

  spd_lane #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_lane_r (
    .clk      (clk),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (s2_wp_r),
    .own_in   (in_data.right_in),
    .cross_in (in_data.left_in),
    .fb_gain  (fb_r),
    .wet_gain (wet_r),
    .dry_gain (dry_r),
    .mix_out  (r_mix)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (mv2) begin
      out_data_r.left_out  <= l_mix;
      out_data_r.right_out <= r_mix;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

/* sv/spd_lane.sv */
module spd_lane
  import spd_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  localparam int AW = $clog2(LINE_DEPTH)
) (
  input  logic                 clk,
  input  lane_ctl_t            ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  sample_t              own_in,
  input  sample_t              cross_in,
  input  logic [FB_BITS-1:0]   fb_gain,
  input  logic [GAIN_BITS-1:0] wet_gain,
  input  logic [GAIN_BITS-1:0] dry_gain,
  output sample_t              mix_out
);

  logic [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];

  // read stage
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic                   zero_r;
  sample_t                own_s1_r;
  sample_t                cross_s1_r;
  sample_t                dl;

  // product stage
  logic signed [SAMPLE_BITS+FB_BITS:0]   fb_p_r;
  logic signed [SAMPLE_BITS+GAIN_BITS:0] wet_p_r;
  logic signed [SAMPLE_BITS+GAIN_BITS:0] dry_p_r;
  sample_t                               cross_s2_r;

  logic signed [SAMPLE_BITS+FB_BITS:0]   fb_sh;
  logic signed [SAMPLE_BITS+GAIN_BITS:0] wet_sh;
  logic signed [SAMPLE_BITS+GAIN_BITS:0] dry_sh;
  logic signed [SUM_BITS-1:0]            store_sum;
  logic signed [SUM_BITS-1:0]            mix_sum;
  sample_t                               store_val;

  // delay line: one read on accept, one write on retire
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= line_mem[rd_addr];
    end
    if (ctl.wr_en) begin
      line_mem[wr_addr] <= store_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      zero_r     <= ctl.rd_zero;
      own_s1_r   <= own_in;
      cross_s1_r <= cross_in;
    end
  end

  // unwritten entries read as zero
  assign dl = zero_r ? '0 : rdata_r;

  // gain products, full precision
  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      fb_p_r     <= $signed({1'b0, fb_gain}) * dl;
      wet_p_r    <= $signed({1'b0, wet_gain}) * dl;
      dry_p_r    <= $signed({1'b0, dry_gain}) * own_s1_r;
      cross_s2_r <= cross_s1_r;
    end
  end

  // floor shift, sum, saturate
  assign fb_sh  = fb_p_r >>> GAIN_SHIFT;
  assign wet_sh = wet_p_r >>> GAIN_SHIFT;
  assign dry_sh = dry_p_r >>> GAIN_SHIFT;

  assign store_sum = {{(SUM_BITS-SAMPLE_BITS){cross_s2_r[SAMPLE_BITS-1]}}, cross_s2_r}
                   + fb_sh[SUM_BITS-1:0];
  assign mix_sum   = wet_sh[SUM_BITS-1:0] + dry_sh[SUM_BITS-1:0];

  assign store_val = sat_sample(store_sum);
  assign mix_out   = sat_sample(mix_sum);

endmodule
